// ===== hw/rtl/dfq_pkg.sv =====
// ----------------------------------------------------------------------------
// dfq_pkg
// shared constants, codes and control types of the deduplicating fifo queue
// ----------------------------------------------------------------------------
package dfq_pkg;

	localparam int Depth     = 16;
	localparam int DataWidth = 32;
	localparam int IdxW      = $clog2(Depth);
	localparam int CntW      = $clog2(Depth + 1);

	// request codes
	localparam logic [1:0] REQ_ENQ    = 2'd0;
	localparam logic [1:0] REQ_DEQ    = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_BADIDX   = 3'd5;

	typedef logic [DataWidth-1:0] data_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} dfq_cmd_t;

endpackage

// ===== hw/rtl/dfq_if.sv =====
// ----------------------------------------------------------------------------
// dfq_req_if / dfq_rsp_if
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
interface dfq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] item_value;
	logic [3:0]  entry_index;

	modport source (output valid, req_type, item_value, entry_index, input ready);
	modport sink (input valid, req_type, item_value, entry_index, output ready);
endinterface

interface dfq_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_value;
	logic [3:0]  result_index;
	logic [2:0]  status;
	logic [4:0]  item_count;

	modport source (output valid, result_value, result_index, status, item_count,
		input ready);
	modport sink (input valid, result_value, result_index, status, item_count,
		output ready);
endinterface

// ===== hw/rtl/dfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfq_ctrl
// two-state sequencer: capture a request word, then apply it once the
// response register is free
// ----------------------------------------------------------------------------
module dfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dfq_pkg::dfq_cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && (state_q == S_IDLE);
	assign cmd.exec  = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.exec) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/dfq_dp.sv =====
// ----------------------------------------------------------------------------
// dfq_dp
// request register, entry register chain with per-cell compare, response
// register
// ----------------------------------------------------------------------------
module dfq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  dfq_pkg::dfq_cmd_t cmd,
	input  logic [1:0]        req_type,
	input  logic [31:0]       item_value,
	input  logic [3:0]        entry_index,
	output logic [31:0]       result_value,
	output logic [3:0]        result_index,
	output logic [2:0]        status,
	output logic [4:0]        item_count
);

	logic [1:0]                    req_type_q;
	dfq_pkg::data_t                item_value_q;
	logic [3:0]                    entry_index_q;
	dfq_pkg::data_t                entries_q [dfq_pkg::Depth];
	logic [dfq_pkg::CntW-1:0]      count_q;

	logic [31:0]                   rval_q;
	logic [3:0]                    ridx_q;
	logic [2:0]                    st_q;

	logic [dfq_pkg::Depth-1:0]     match;
	logic                          hit;
	logic [dfq_pkg::IdxW-1:0]      hit_pos;
	logic                          full;
	logic                          empty;
	logic                          enq_ok;
	logic                          deq_ok;
	logic                          bad_idx;
	dfq_pkg::data_t                rval;
	logic [3:0]                    ridx;
	logic [2:0]                    st;
	logic [dfq_pkg::CntW-1:0]      count_d;

	// per-cell compare against the held value
	always_comb begin
		for (int i = 0; i < dfq_pkg::Depth; i++) begin
			match[i] = (32'(i) < 32'(count_q)) && (entries_q[i] == item_value_q);
		end
	end

	// nearest-to-head match
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int i = dfq_pkg::Depth - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_pos = dfq_pkg::IdxW'(i);
			end
		end
	end

	assign full    = (32'(count_q) >= 32'(dfq_pkg::Depth));
	assign empty   = (count_q == '0);
	assign bad_idx = (32'(entry_index_q) >= 32'(count_q));

	always_comb begin
		rval    = '0;
		ridx    = '0;
		st      = dfq_pkg::ST_OK;
		enq_ok  = 1'b0;
		deq_ok  = 1'b0;
		count_d = count_q;
		case (req_type_q)
			dfq_pkg::REQ_ENQ: begin
				if (full) begin
					st = dfq_pkg::ST_FULL;
				end else if (hit) begin
					st = dfq_pkg::ST_DUP;
				end else begin
					enq_ok  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			dfq_pkg::REQ_DEQ: begin
				if (empty) begin
					st = dfq_pkg::ST_EMPTY;
				end else begin
					deq_ok  = 1'b1;
					rval    = entries_q[0];
					count_d = count_q - 1'b1;
				end
			end
			dfq_pkg::REQ_SEARCH: begin
				if (hit) begin
					ridx = 4'(hit_pos);
				end else begin
					st = dfq_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				if (bad_idx) begin
					st = dfq_pkg::ST_BADIDX;
				end else begin
					rval = entries_q[dfq_pkg::IdxW'(entry_index_q)];
				end
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q    <= req_type;
			item_value_q  <= dfq_pkg::DataWidth'(item_value);
			entry_index_q <= entry_index;
		end
	end

	// entry chain: shift toward head on dequeue, write tail cell on enqueue
	always_ff @(posedge clk) begin
		for (int i = 0; i < dfq_pkg::Depth; i++) begin
			if (cmd.exec && deq_ok && (i < dfq_pkg::Depth - 1)) begin
				entries_q[i] <= entries_q[(i + 1) % dfq_pkg::Depth];
			end else if (cmd.exec && enq_ok && (32'(count_q) == 32'(i))) begin
				entries_q[i] <= item_value_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rval_q <= 32'(rval);
			ridx_q <= ridx;
			st_q   <= st;
		end
	end

	assign result_value = rval_q;
	assign result_index = ridx_q;
	assign status       = st_q;
	assign item_count   = 5'(count_q);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(dfq_pkg::Depth))
		else $error("entry count above capacity");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && enq_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("accepted enqueue did not grow count");

	a_deq_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && deq_ok |=> count_q == $past(count_q) - 1'b1)
		else $error("dequeue did not shrink count");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("duplicate value held in queue");
`endif

endmodule

// ===== hw/rtl/dedup_fifo_queue_core.sv =====
// ----------------------------------------------------------------------------
// dedup_fifo_queue_core
// first-in first-out queue of unique values with search and indexed read
// ----------------------------------------------------------------------------
// Each request word is captured in the request register and then applied
// against the 16-cell entry register chain, where every cell compares
// against the request value in parallel and the chain shifts one place on a
// dequeue. A new request is taken as soon as the previous one has been
// applied, even while its response word still waits in the output register;
// the apply cycle itself waits until that register is free. Every request
// gives exactly one response word carrying the entry count after it.
module dedup_fifo_queue_core (
	input  logic    clk,
	input  logic    arst_n,
	dfq_req_if.sink req,
	dfq_rsp_if.source rsp
);

	dfq_pkg::dfq_cmd_t cmd;

	// sequencer: handshakes and apply timing
	dfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// entry chain, compare cells and response register
	dfq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req.req_type),
		.item_value   (req.item_value),
		.entry_index  (req.entry_index),
		.result_value (rsp.result_value),
		.result_index (rsp.result_index),
		.status       (rsp.status),
		.item_count   (rsp.item_count)
	);

endmodule

// ===== verif/tb_dedup_fifo_queue_core.sv =====
// ----------------------------------------------------------------------------
// tb_dedup_fifo_queue_core
// self-checking bench for the deduplicating fifo queue core: a tracker keeps
// its own copy of the queue, predicts the response word of every accepted
// request and compares it field by field with what comes out, while both
// channels idle and stall at random and the response side holds off once
// long enough to back the queue up into its request channel
// ----------------------------------------------------------------------------
module tb_dedup_fifo_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkPeriod    = 8;
	localparam int RandomWords  = 1450;
	localparam int HoldCycles   = 300;
	localparam int CycleLimit   = 400000;
	localparam int PoolSize     = 24;
	localparam int DrainCycles  = 10;

	// one response word as the queue should produce it
	typedef struct packed {
		dfq_pkg::data_t             res_value;
		logic [dfq_pkg::IdxW-1:0]   res_index;
		logic [2:0]                 res_status;
		logic [dfq_pkg::CntW-1:0]   res_count;
	} dfq_result_t;

	// mirror of the queue contents plus the responses still owed
	class dedup_queue_tracker;
		dfq_pkg::data_t shadow_cells[$];
		dfq_result_t    expected_results[$];
		int             errors;

		function new();
			errors = 0;
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t mismatch %s expected %h actual %h", $time, what, want, got);
		endfunction

		// apply one accepted request to the mirror and queue its response
		function void note_request(logic [1:0] kind, dfq_pkg::data_t value,
			logic [3:0] pos);
			dfq_result_t r;
			int          hit;
			int          i;
			r = '0;
			r.res_status = dfq_pkg::ST_OK;
			hit = -1;
			for (i = 0; i < shadow_cells.size(); i++)
				if (hit < 0 && shadow_cells[i] == value) hit = i;
			case (kind)
				dfq_pkg::REQ_ENQ: begin
					// capacity is checked before uniqueness
					if (shadow_cells.size() >= dfq_pkg::Depth) r.res_status = dfq_pkg::ST_FULL;
					else if (hit >= 0) r.res_status = dfq_pkg::ST_DUP;
					else shadow_cells.push_back(value);
				end
				dfq_pkg::REQ_DEQ: begin
					if (shadow_cells.size() == 0) r.res_status = dfq_pkg::ST_EMPTY;
					else r.res_value = shadow_cells.pop_front();
				end
				dfq_pkg::REQ_SEARCH: begin
					if (hit < 0) r.res_status = dfq_pkg::ST_NOTFOUND;
					else r.res_index = dfq_pkg::IdxW'(hit);
				end
				default: begin
					if (int'(pos) >= shadow_cells.size()) r.res_status = dfq_pkg::ST_BADIDX;
					else r.res_value = shadow_cells[pos];
				end
			endcase
			r.res_count = dfq_pkg::CntW'(shadow_cells.size());
			expected_results.push_back(r);
		endfunction

		// compare one accepted response word with the oldest prediction
		function void check_response(dfq_result_t got);
			dfq_result_t want;
			if (expected_results.size() == 0) begin
				flag("unexpected response word", '0, 32'(got.res_value));
				return;
			end
			want = expected_results.pop_front();
			if (got.res_value !== want.res_value)
				flag("result_value", 32'(want.res_value), 32'(got.res_value));
			if (got.res_index !== want.res_index)
				flag("result_index", 32'(want.res_index), 32'(got.res_index));
			if (got.res_status !== want.res_status)
				flag("status", 32'(want.res_status), 32'(got.res_status));
			if (got.res_count !== want.res_count)
				flag("item_count", 32'(want.res_count), 32'(got.res_count));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dfq_req_if req_bus();
	dfq_rsp_if rsp_bus();

	dedup_fifo_queue_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus.sink),
		.rsp    (rsp_bus.source)
	);

	dedup_queue_tracker tracker = new();

	// calm: no idling on either side for a stretch of words
	bit             calm;
	// set by the stimulus, taken and cleared by the response sink
	bit             hold_request;
	int             cycle_count;
	dfq_pkg::data_t value_pool[PoolSize];

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, tracker.outstanding());
			$display("== FAIL ==");
			$finish;
		end
	end

	// both monitors sample the pre-edge values of the handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready)
				tracker.check_response({rsp_bus.result_value, rsp_bus.result_index,
					rsp_bus.status, rsp_bus.item_count});
			if (req_bus.valid && req_bus.ready)
				tracker.note_request(req_bus.req_type, req_bus.item_value,
					req_bus.entry_index);
		end
	end

	// response sink: random stalls, full speed when calm, one long hold-off
	initial begin : rsp_sink
		int stretch;
		rsp_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				// long hold-off, counted here while the sender keeps offering words
				hold_request = 1'b0;
				rsp_bus.ready <= 1'b0;
				stretch = HoldCycles;
			end else if (calm) begin
				rsp_bus.ready <= 1'b1;
				stretch = 1;
			end else if ($urandom_range(0, 9) < 3) begin
				rsp_bus.ready <= 1'b0;
				stretch = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 2);
			end else begin
				rsp_bus.ready <= 1'b1;
				stretch = $urandom_range(1, 8);
			end
			repeat (stretch) @(posedge clk);
		end
	end

	// idle gap after an accepted request word: mostly none, a few long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one request word and hold it until accepted
	task automatic send_word(input logic [1:0] kind, input dfq_pkg::data_t value,
		input logic [3:0] pos);
		int gap;
		req_bus.valid       <= 1'b1;
		req_bus.req_type    <= kind;
		req_bus.item_value  <= value;
		req_bus.entry_index <= pos;
		do @(posedge clk); while (!req_bus.ready);
		gap = pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// value for enqueue or search: mostly from a small pool so that
	// duplicates and search hits are common
	function automatic dfq_pkg::data_t pick_value();
		if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, PoolSize - 1)];
		return dfq_pkg::data_t'($urandom);
	endfunction

	task automatic random_word(input int enq_bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < enq_bias)
			send_word(dfq_pkg::REQ_ENQ, pick_value(), 4'($urandom));
		else begin
			r = $urandom_range(0, 9);
			if (r < 4)
				send_word(dfq_pkg::REQ_DEQ, dfq_pkg::data_t'($urandom), 4'($urandom));
			else if (r < 7)
				send_word(dfq_pkg::REQ_SEARCH, pick_value(), 4'($urandom));
			else
				send_word(dfq_pkg::REQ_READ, dfq_pkg::data_t'($urandom),
					4'($urandom_range(0, 15)));
		end
	endtask

	initial begin : stimulus
		int n;
		int k;
		int enq_bias;

		// every input known from time zero
		arst_n              <= 1'b0;
		req_bus.valid       <= 1'b0;
		req_bus.req_type    <= dfq_pkg::REQ_ENQ;
		req_bus.item_value  <= '0;
		req_bus.entry_index <= '0;
		calm         = 1'b0;
		hold_request = 1'b0;
		cycle_count  = 0;

		for (k = 0; k < PoolSize; k++) value_pool[k] = dfq_pkg::data_t'($urandom);
		value_pool[0] = '0;
		value_pool[1] = '1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: dequeue, read and search all fail
		send_word(dfq_pkg::REQ_DEQ, '0, '0);
		send_word(dfq_pkg::REQ_READ, '0, 4'd0);
		send_word(dfq_pkg::REQ_SEARCH, '0, '0);

		// value extremes, a duplicate, search hit and miss, reads in and out of range
		send_word(dfq_pkg::REQ_ENQ, '0, '0);
		send_word(dfq_pkg::REQ_ENQ, '1, '1);
		send_word(dfq_pkg::REQ_ENQ, '0, '0);
		send_word(dfq_pkg::REQ_SEARCH, '1, '0);
		send_word(dfq_pkg::REQ_SEARCH, 32'h0001_2345, '0);
		send_word(dfq_pkg::REQ_READ, '0, 4'd1);
		send_word(dfq_pkg::REQ_READ, '0, 4'd2);

		// fill to capacity with walking ones
		for (k = 0; k < dfq_pkg::Depth - 2; k++)
			send_word(dfq_pkg::REQ_ENQ, dfq_pkg::data_t'(1) << (k * 2 + 1), '0);

		// full queue rejects a new value, and a duplicate with full status too
		send_word(dfq_pkg::REQ_ENQ, 32'h5a5a_a5a5, '0);
		send_word(dfq_pkg::REQ_ENQ, '0, '0);
		send_word(dfq_pkg::REQ_READ, '0, 4'd15);
		send_word(dfq_pkg::REQ_SEARCH,
			dfq_pkg::data_t'(1) << ((dfq_pkg::Depth - 3) * 2 + 1), '0);
		send_word(dfq_pkg::REQ_DEQ, '0, '0);

		// random part in segments, each with its own fill bias and idling mode
		enq_bias = 50;
		for (n = 0; n < RandomWords; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_bias = 25;
					1: enq_bias = 50;
					default: enq_bias = 75;
				endcase
				calm = ($urandom_range(0, 4) == 0);
			end
			if (n % 150 == 75)
				for (k = 0; k < 4; k++)
					value_pool[$urandom_range(2, PoolSize - 1)] = dfq_pkg::data_t'($urandom);
			// back the queue up into its request channel once
			if (n == 400) begin
				calm = 1'b0;
				hold_request = 1'b1;
			end
			random_word(enq_bias);
		end

		req_bus.valid <= 1'b0;
		calm = 1'b1;
		// let the monitor note the last accepted word before draining
		@(posedge clk);
		while (tracker.outstanding() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== dedup_fifo_queue_core.f =====
hw/rtl/dfq_pkg.sv
hw/rtl/dfq_if.sv
hw/rtl/dfq_ctrl.sv
hw/rtl/dfq_dp.sv
hw/rtl/dedup_fifo_queue_core.sv
verif/tb_dedup_fifo_queue_core.sv
